// ----- hw/rtl/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg
// Types, constants and the CRC-32 byte function for the packet deframer.
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [7:0] MAGIC_B0 = 8'h52;
	localparam logic [7:0] MAGIC_B1 = 8'h56;
	localparam logic [7:0] MAGIC_B2 = 8'h52;
	localparam logic [7:0] MAGIC_B3 = 8'h54;

	localparam logic [7:0] VERSION_RESET = 8'd1;

	localparam logic [1:0] VERDICT_OK        = 2'd0;
	localparam logic [1:0] VERDICT_BAD_HDR   = 2'd1;
	localparam logic [1:0] VERDICT_CRC_ERR   = 2'd2;
	localparam logic [1:0] VERDICT_ABORTED   = 2'd3;

	localparam logic REG_EXPECTED_VERSION = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       start_of_packet;
	} rx_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [7:0]  command_code;
		logic [7:0]  status_code;
		logic [31:0] payload_length;
		logic [31:0] received_crc;
	} result_t;

	// Reflected CRC-32 over one byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/packet_deframer_crc32_check_unit.sv -----
// ----------------------------------------------------------------------------
// packet_deframer_crc32_check_unit
// Parses a 16-byte packet header, checks magic/version/reserved and the CRC-32
// over header bytes 0..11 and the payload, and gives one verdict per packet.
// ----------------------------------------------------------------------------
// Usage:
//   byte_* channel takes one packet byte per item, start_of_packet set on
//   header byte 0. verdict_* channel gives at most one result per byte:
//   bad header, CRC pass/fail at packet end, or abort when a new start cuts
//   a packet short. Payload bytes are consumed, never forwarded.
//   expected_version sits at APB address 0 (reset value 1); write it only
//   while no packet is in flight.
// Timing:
//   One byte per cycle sustained unless a held result stalls it. A byte is
//   registered on accept, processed from that register, and its result registered.
//   The per-byte CRC update is one unrolled XOR network, which with the
//   32-bit remaining-count compare sets the cycle.
// Reset: parser returns to idle, CRC to all ones, held fields to zero.
// Stall: a held result blocks only bytes that would produce another result;
//   the input register then holds and byte_ready drops.
// ----------------------------------------------------------------------------
module packet_deframer_crc32_check_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  pdc_pkg::rx_item_t  byte_item,
	output logic               verdict_valid,
	input  logic               verdict_ready,
	output pdc_pkg::result_t   verdict_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic              valid_s1;
	pdc_pkg::rx_item_t item_s1;

	pdc_pkg::phase_t   phase_q;
	logic [3:0]        hdr_idx_q;
	logic [31:0]       crc_q;
	logic [7:0]        cmd_q;
	logic [7:0]        sts_q;
	logic [31:0]       len_q;
	logic [31:0]       hcrc_q;
	logic [31:0]       remain_q;
	logic              bad_q;
	logic [7:0]        version_q;

	pdc_pkg::phase_t   nx_phase;
	logic [3:0]        nx_idx;
	logic [31:0]       nx_crc;
	logic [7:0]        nx_cmd;
	logic [7:0]        nx_sts;
	logic [31:0]       nx_len;
	logic [31:0]       nx_hcrc;
	logic [31:0]       nx_remain;
	logic              nx_bad;
	logic              res_any;
	pdc_pkg::result_t  res;

	logic              out_valid_q;
	pdc_pkg::result_t  out_q;
	logic              advance;

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == pdc_pkg::REG_EXPECTED_VERSION) ? {24'd0, version_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= pdc_pkg::VERSION_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == pdc_pkg::REG_EXPECTED_VERSION) begin
			version_q <= pwdata[7:0];
		end
	end

	// Byte processing
	always_comb begin
		nx_phase  = phase_q;
		nx_idx    = hdr_idx_q;
		nx_crc    = crc_q;
		nx_cmd    = cmd_q;
		nx_sts    = sts_q;
		nx_len    = len_q;
		nx_hcrc   = hcrc_q;
		nx_remain = remain_q;
		nx_bad    = bad_q;
		res_any   = 1'b0;
		res       = '{verdict: pdc_pkg::VERDICT_ABORTED, command_code: cmd_q,
		              status_code: sts_q, payload_length: len_q, received_crc: hcrc_q};

		if (item_s1.start_of_packet) begin
			if (phase_q == pdc_pkg::PH_HEADER || phase_q == pdc_pkg::PH_PAYLOAD) begin
				res_any = 1'b1;
			end
			nx_phase  = pdc_pkg::PH_HEADER;
			nx_idx    = 4'd0;
			nx_crc    = pdc_pkg::CRC_INIT;
			nx_cmd    = 8'd0;
			nx_sts    = 8'd0;
			nx_len    = 32'd0;
			nx_hcrc   = 32'd0;
			nx_remain = 32'd0;
			nx_bad    = 1'b0;
		end

		case (nx_phase)
			pdc_pkg::PH_HEADER: begin
				if (nx_idx < 4'd12) begin
					nx_crc = pdc_pkg::crc_byte(nx_crc, item_s1.rx_byte);
				end
				case (nx_idx)
					4'd0: if (item_s1.rx_byte != pdc_pkg::MAGIC_B0) nx_bad = 1'b1;
					4'd1: if (item_s1.rx_byte != pdc_pkg::MAGIC_B1) nx_bad = 1'b1;
					4'd2: if (item_s1.rx_byte != pdc_pkg::MAGIC_B2) nx_bad = 1'b1;
					4'd3: if (item_s1.rx_byte != pdc_pkg::MAGIC_B3) nx_bad = 1'b1;
					4'd4: if (item_s1.rx_byte != version_q) nx_bad = 1'b1;
					4'd5: nx_cmd = item_s1.rx_byte;
					4'd6: nx_sts = item_s1.rx_byte;
					4'd7: if (item_s1.rx_byte != 8'd0) nx_bad = 1'b1;
					default: begin
						if (nx_idx < 4'd12) begin
							nx_len[{nx_idx[1:0], 3'b000} +: 8] =
								nx_len[{nx_idx[1:0], 3'b000} +: 8] | item_s1.rx_byte;
						end else begin
							nx_hcrc[{nx_idx[1:0], 3'b000} +: 8] =
								nx_hcrc[{nx_idx[1:0], 3'b000} +: 8] | item_s1.rx_byte;
						end
					end
				endcase
				if (nx_idx == 4'd15) begin
					nx_idx = 4'd0;
					res    = '{verdict: pdc_pkg::VERDICT_BAD_HDR, command_code: nx_cmd,
					           status_code: nx_sts, payload_length: nx_len,
					           received_crc: nx_hcrc};
					if (nx_bad) begin
						res_any  = 1'b1;
						nx_phase = pdc_pkg::PH_IDLE;
					end else if (nx_len == 32'd0) begin
						res_any     = 1'b1;
						res.verdict = ((nx_crc ^ pdc_pkg::CRC_INIT) == nx_hcrc) ?
						              pdc_pkg::VERDICT_OK : pdc_pkg::VERDICT_CRC_ERR;
						nx_phase    = pdc_pkg::PH_IDLE;
					end else begin
						nx_remain = nx_len;
						nx_phase  = pdc_pkg::PH_PAYLOAD;
					end
				end else begin
					nx_idx = nx_idx + 4'd1;
				end
			end
			pdc_pkg::PH_PAYLOAD: begin
				nx_crc    = pdc_pkg::crc_byte(crc_q, item_s1.rx_byte);
				nx_remain = remain_q - 32'd1;
				if (nx_remain == 32'd0) begin
					res_any     = 1'b1;
					res.verdict = ((nx_crc ^ pdc_pkg::CRC_INIT) == hcrc_q) ?
					              pdc_pkg::VERDICT_OK : pdc_pkg::VERDICT_CRC_ERR;
					nx_phase    = pdc_pkg::PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	assign advance    = valid_s1 && (!res_any || !out_valid_q || verdict_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pdc_pkg::PH_IDLE;
			hdr_idx_q <= 4'd0;
			crc_q     <= pdc_pkg::CRC_INIT;
			cmd_q     <= 8'd0;
			sts_q     <= 8'd0;
			len_q     <= 32'd0;
			hcrc_q    <= 32'd0;
			remain_q  <= 32'd0;
			bad_q     <= 1'b0;
		end else if (advance) begin
			phase_q   <= nx_phase;
			hdr_idx_q <= nx_idx;
			crc_q     <= nx_crc;
			cmd_q     <= nx_cmd;
			sts_q     <= nx_sts;
			len_q     <= nx_len;
			hcrc_q    <= nx_hcrc;
			remain_q  <= nx_remain;
			bad_q     <= nx_bad;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_any) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_any) begin
			out_q <= res;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict_item  = out_q;

endmodule
